>>> design/nsled_pkg.sv
// ============================================================================
// nsled_pkg
// Shared types, codes and constants of the network status LED pattern driver.
// ============================================================================
package nsled_pkg;

    // Configuration register width and index width.
    localparam int CFG_WIDTH       = 16;
    localparam int CFG_INDEX_WIDTH = 2;

    // Configuration register indexes.
    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        CFG_FLICKER   = 2'd0,
        CFG_BLINK     = 2'd1,
        CFG_FLASH_ON  = 2'd2,
        CFG_FLASH_OFF = 2'd3
    } t_cfg_index;

    // Configuration reset values.
    localparam logic [CFG_WIDTH-1:0] FLICKER_RESET   = 16'd50;
    localparam logic [CFG_WIDTH-1:0] BLINK_RESET     = 16'd200;
    localparam logic [CFG_WIDTH-1:0] FLASH_ON_RESET  = 16'd200;
    localparam logic [CFG_WIDTH-1:0] FLASH_OFF_RESET = 16'd1000;

    // Transaction kinds.
    localparam logic OP_TICK  = 1'b0;
    localparam logic OP_EVENT = 1'b1;

    // Status classes carried by a state change event.
    localparam logic [2:0] CLS_OFF       = 3'd0;
    localparam logic [2:0] CLS_ON        = 3'd1;
    localparam logic [2:0] CLS_FLICKER   = 3'd2;
    localparam logic [2:0] CLS_BLINK     = 3'd3;
    localparam logic [2:0] CLS_SINGLE    = 3'd4;
    localparam logic [2:0] CLS_DOUBLE    = 3'd5;
    localparam logic [2:0] CLS_TRIPLE    = 3'd6;
    localparam logic [2:0] CLS_NO_CHANGE = 3'd7;

    // Error LED actions.
    localparam logic [1:0] ERR_NONE  = 2'd0;
    localparam logic [1:0] ERR_CLEAR = 2'd1;
    localparam logic [1:0] ERR_SET   = 2'd2;

    // Phase handling.
    localparam logic [3:0] PHASE_TOP          = 4'd15;
    localparam logic [4:0] BLINK_LIMIT        = 5'd2;
    localparam logic [4:0] FLASH_LIMIT_SINGLE = 5'd2;
    localparam logic [4:0] FLASH_LIMIT_DOUBLE = 5'd4;
    localparam logic [4:0] FLASH_LIMIT_TRIPLE = 5'd6;

    // Pattern mode, one-hot.
    typedef enum logic [7:0] {
        MODE_INIT    = 8'b0000_0001,
        MODE_OFF     = 8'b0000_0010,
        MODE_ON      = 8'b0000_0100,
        MODE_FLICKER = 8'b0000_1000,
        MODE_BLINK   = 8'b0001_0000,
        MODE_SINGLE  = 8'b0010_0000,
        MODE_DOUBLE  = 8'b0100_0000,
        MODE_TRIPLE  = 8'b1000_0000
    } t_mode;

    // Input transaction payload.
    typedef struct packed {
        logic       operation;
        logic [2:0] status_class;
        logic [1:0] error_action;
    } t_in_item;

    // Result transaction payload.
    typedef struct packed {
        logic status_led;
        logic status_report;
        logic error_led;
        logic error_report;
    } t_out_item;

    // Pattern durations handed from the register file to the core.
    typedef struct packed {
        logic [CFG_WIDTH-1:0] flicker_ticks;
        logic [CFG_WIDTH-1:0] blink_ticks;
        logic [CFG_WIDTH-1:0] flash_on_ticks;
        logic [CFG_WIDTH-1:0] flash_off_ticks;
    } t_cfg;

    // Mode that a status class selects.
    function automatic t_mode class_to_mode(input logic [2:0] cls);
        t_mode mode;
        case (cls)
            CLS_OFF:     mode = MODE_OFF;
            CLS_ON:      mode = MODE_ON;
            CLS_FLICKER: mode = MODE_FLICKER;
            CLS_BLINK:   mode = MODE_BLINK;
            CLS_SINGLE:  mode = MODE_SINGLE;
            CLS_DOUBLE:  mode = MODE_DOUBLE;
            CLS_TRIPLE:  mode = MODE_TRIPLE;
            default:     mode = MODE_INIT;
        endcase
        return mode;
    endfunction

    // Phase count at which a flash group ends.
    function automatic logic [4:0] flash_limit(input t_mode mode);
        logic [4:0] limit;
        case (mode)
            MODE_DOUBLE: limit = FLASH_LIMIT_DOUBLE;
            MODE_TRIPLE: limit = FLASH_LIMIT_TRIPLE;
            default:     limit = FLASH_LIMIT_SINGLE;
        endcase
        return limit;
    endfunction

endpackage

>>> design/nsled_cfg.sv
// ============================================================================
// nsled_cfg
// Configuration register file holding the four pattern durations.
// ============================================================================
module nsled_cfg (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [nsled_pkg::CFG_INDEX_WIDTH-1:0] i_cfg_index,
    input  logic [nsled_pkg::CFG_WIDTH-1:0]       i_cfg_data,
    output nsled_pkg::t_cfg                      o_cfg
);
    import nsled_pkg::*;

    t_cfg r_cfg;

    // Registers load their defaults at reset and take a write whenever enabled.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.flicker_ticks   <= FLICKER_RESET;
            r_cfg.blink_ticks     <= BLINK_RESET;
            r_cfg.flash_on_ticks  <= FLASH_ON_RESET;
            r_cfg.flash_off_ticks <= FLASH_OFF_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_FLICKER:   r_cfg.flicker_ticks   <= i_cfg_data;
                CFG_BLINK:     r_cfg.blink_ticks     <= i_cfg_data;
                CFG_FLASH_ON:  r_cfg.flash_on_ticks  <= i_cfg_data;
                CFG_FLASH_OFF: r_cfg.flash_off_ticks <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

>>> design/nsled_core.sv
// ============================================================================
// nsled_core
// Pattern state and the single-step update for one tick or event transaction.
// ============================================================================
module nsled_core #(
    parameter int TICK_WIDTH = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_step,
    input  nsled_pkg::t_in_item   i_item,
    input  nsled_pkg::t_cfg       i_cfg,
    output nsled_pkg::t_out_item  o_result
);
    import nsled_pkg::*;

    t_mode                 r_mode, n_mode;
    logic [3:0]            r_phase, n_phase;
    logic [TICK_WIDTH-1:0] r_ticks, n_ticks;
    logic                  r_running, n_running;
    logic                  r_status, n_status;
    logic                  r_error, n_error;

    logic [TICK_WIDTH-1:0] w_ticks_pre;
    logic                  w_running_pre;
    logic                  w_load;
    logic [CFG_WIDTH-1:0]  w_dur;
    logic [TICK_WIDTH-1:0] w_sat;
    logic [TICK_WIDTH-1:0] w_load_value;
    logic [4:0]            w_next_phase;
    logic [4:0]            w_limit;
    t_mode                 w_new_mode;
    logic                  w_srep;
    logic                  w_erep;

    assign w_next_phase = {1'b0, r_phase} + 5'd1;
    assign w_limit      = flash_limit(r_mode);
    assign w_new_mode   = class_to_mode(i_item.status_class);

    // Decide the next pattern state and which duration, if any, to load.
    always_comb begin
        n_mode        = r_mode;
        n_phase       = r_phase;
        w_ticks_pre   = r_ticks;
        w_running_pre = r_running;
        n_status      = r_status;
        n_error       = r_error;
        w_load        = 1'b0;
        w_dur         = i_cfg.flash_on_ticks;
        w_srep        = 1'b0;
        w_erep        = 1'b0;

        if (i_item.operation == OP_TICK) begin
            if (r_running) begin
                if (r_ticks <= TICK_WIDTH'(1)) begin
                    // Timer expired: advance the pattern by one phase.
                    w_ticks_pre = '0;
                    case (r_mode)
                        MODE_FLICKER, MODE_BLINK: begin
                            if (w_next_phase >= BLINK_LIMIT) begin
                                n_phase  = 4'd0;
                                n_status = 1'b0;
                            end else begin
                                n_phase  = w_next_phase[3:0];
                                n_status = 1'b1;
                            end
                            w_dur  = (r_mode == MODE_FLICKER) ? i_cfg.flicker_ticks
                                                              : i_cfg.blink_ticks;
                            w_load = 1'b1;
                            w_srep = 1'b1;
                        end
                        MODE_SINGLE, MODE_DOUBLE, MODE_TRIPLE: begin
                            if (w_next_phase >= w_limit) begin
                                n_phase  = 4'd0;
                                n_status = 1'b0;
                                w_dur    = i_cfg.flash_off_ticks;
                            end else begin
                                n_phase  = w_next_phase[3:0];
                                n_status = w_next_phase[0];
                                w_dur    = i_cfg.flash_on_ticks;
                            end
                            w_load = 1'b1;
                            w_srep = 1'b1;
                        end
                        default: begin
                            w_running_pre = 1'b0;
                        end
                    endcase
                end else begin
                    w_ticks_pre = r_ticks - TICK_WIDTH'(1);
                end
            end
        end else begin
            // State change event.
            if (i_item.status_class != CLS_NO_CHANGE && w_new_mode != r_mode) begin
                n_mode = w_new_mode;
                if (w_new_mode == MODE_OFF || w_new_mode == MODE_ON) begin
                    w_running_pre = 1'b0;
                    w_ticks_pre   = '0;
                    n_status      = (w_new_mode == MODE_ON);
                    w_srep        = 1'b1;
                end else if (r_mode == MODE_OFF || r_mode == MODE_ON) begin
                    // Starting a pattern from a steady level begins at once.
                    n_status = (r_mode == MODE_OFF);
                    n_phase  = (r_mode == MODE_OFF) ? PHASE_TOP : 4'd0;
                    if (w_new_mode == MODE_FLICKER) begin
                        w_dur = i_cfg.flicker_ticks;
                    end else if (w_new_mode == MODE_BLINK) begin
                        w_dur = i_cfg.blink_ticks;
                    end else if (r_mode == MODE_OFF) begin
                        w_dur = i_cfg.flash_on_ticks;
                    end else begin
                        w_dur = i_cfg.flash_off_ticks;
                    end
                    w_load = 1'b1;
                    w_srep = 1'b1;
                end
            end

            // Error LED follows its action code; the unused code does nothing.
            if (i_item.error_action == ERR_CLEAR) begin
                n_error = 1'b0;
                w_erep  = 1'b1;
            end else if (i_item.error_action == ERR_SET) begin
                n_error = 1'b1;
                w_erep  = 1'b1;
            end
        end
    end

    // Fit the 16-bit duration to the timer width, saturating when it is narrower.
    generate
        if (TICK_WIDTH >= CFG_WIDTH) begin : g_wide
            assign w_sat = TICK_WIDTH'(w_dur);
        end else begin : g_narrow
            assign w_sat = (|w_dur[CFG_WIDTH-1:TICK_WIDTH]) ? '1 : w_dur[TICK_WIDTH-1:0];
        end
    endgenerate

    // A zero duration behaves as one tick.
    assign w_load_value = (w_sat == '0) ? TICK_WIDTH'(1) : w_sat;

    assign n_ticks   = w_load ? w_load_value : w_ticks_pre;
    assign n_running = w_load | w_running_pre;

    // Pattern state advances once per processed transaction.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= MODE_INIT;
            r_phase   <= 4'd0;
            r_ticks   <= '0;
            r_running <= 1'b0;
            r_status  <= 1'b0;
            r_error   <= 1'b0;
        end else if (i_step) begin
            r_mode    <= n_mode;
            r_phase   <= n_phase;
            r_ticks   <= n_ticks;
            r_running <= n_running;
            r_status  <= n_status;
            r_error   <= n_error;
        end
    end

    // Result of the transaction being processed.
    always_comb begin
        o_result.status_led    = n_status;
        o_result.status_report = w_srep;
        o_result.error_led     = n_error;
        o_result.error_report  = w_erep;
    end

endmodule

>>> design/network_status_led_pattern_driver.sv
// ============================================================================
// network_status_led_pattern_driver
// Status and error LED pattern driver for a network node.
// ============================================================================
// Usage:
// The input channel (i_in_valid, i_in_item, o_in_stall) carries one transaction
// per millisecond tick or per network state change event. Every input
// transaction yields exactly one result transaction on the output channel
// (o_out_valid, o_out_item, i_out_stall) holding both LED levels and report
// flags. An accepted transaction is held in the input register while the
// combinational pattern logic computes its result, which the output register
// takes as soon as it is empty or being drained.
// Throughput is one transaction per cycle while the receiver does not stall;
// the pattern update between the two registers is combinational.
// The configuration port writes one duration register per enabled cycle and
// should only be used while no transaction is in flight.
// Reset (synchronous, active low) clears both pipeline valid flags, puts the
// pattern in its initial mode with both LEDs dark and loads default durations.
// While the receiver stalls, the output holds; the input register still takes
// one more transaction, after which o_in_stall goes high.
// ============================================================================
module network_status_led_pattern_driver #(
    parameter int TICK_WIDTH = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    input  nsled_pkg::t_in_item                   i_in_item,
    output logic                                  o_in_stall,
    output logic                                  o_out_valid,
    output nsled_pkg::t_out_item                  o_out_item,
    input  logic                                  i_out_stall,
    input  logic                                  i_cfg_we,
    input  logic [nsled_pkg::CFG_INDEX_WIDTH-1:0] i_cfg_index,
    input  logic [nsled_pkg::CFG_WIDTH-1:0]       i_cfg_data
);
    import nsled_pkg::*;

    logic      r_in_valid;
    t_in_item  r_in_item;
    logic      r_out_valid;
    t_out_item r_out_item;

    logic      w_advance;
    logic      w_step;
    t_cfg      w_cfg;
    t_out_item w_result;

    // The output register can take a new result when empty or being drained.
    assign w_advance  = !r_out_valid || !i_out_stall;
    assign w_step     = r_in_valid && w_advance;
    assign o_in_stall = r_in_valid && !w_advance;

    // Duration registers.
    nsled_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    // Pattern state and update logic.
    nsled_core #(
        .TICK_WIDTH (TICK_WIDTH)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (w_step),
        .i_item   (r_in_item),
        .i_cfg    (w_cfg),
        .o_result (w_result)
    );

    // Pipeline valid flags.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (!o_in_stall) begin
                r_in_valid <= i_in_valid;
            end
            if (w_advance) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    // Pipeline payload registers.
    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in_item <= i_in_item;
        end
        if (w_step) begin
            r_out_item <= w_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

>>> design/nsled_chk.sv
// ============================================================================
// nsled_chk
// Port-level checker for the network status LED pattern driver.
// ============================================================================
module nsled_chk (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    input  logic                                  o_in_stall,
    input  logic                                  o_out_valid,
    input  nsled_pkg::t_out_item                  o_out_item,
    input  logic                                  i_out_stall
);

    // A stalled result transaction holds its valid and payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_item))
        else $error("result transaction changed while stalled");

    // The input side only stalls when a finished result is blocked downstream.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled without a blocked result");

    // A fresh result must follow an accepted input transaction.
    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(i_in_valid && !o_in_stall, 2))
        else $error("result appeared without a matching input transaction");

    // Nothing is offered right after reset.
    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_out_valid && !o_in_stall)
        else $error("pipeline not empty after reset");

endmodule

bind network_status_led_pattern_driver nsled_chk u_nsled_chk (.*);

>>> tb/tb_network_status_led_pattern_driver.sv
`timescale 1ns / 100ps
// ============================================================================
// tb_network_status_led_pattern_driver
// Self-checking testbench for the network status LED pattern driver.
// ============================================================================
// Ticks and state change events go in through a driver that is fed from a
// queue. Each accepted transaction is run through an in-bench model of the
// pattern logic. The LED state that the model predicts is queued and compared
// field by field with the result transactions. A directed opening covers the
// initial mode, off and on, the entry into a pattern from off and from on,
// switches between patterns and the error LED actions. Random phases follow,
// one for each set of durations: the minimum, small random values, the
// maximum, mixes of these and values across the full range. Both sides
// idle at random, except during one phase with no idling at all.
// ============================================================================
module tb_network_status_led_pattern_driver;

    import nsled_pkg::*;

    localparam int TICK_WIDTH     = 16;
    localparam int SETTLE_CYCLES  = 6;
    localparam int WATCHDOG_LIMIT = 5000;

    // Block ports.
    logic                       i_clk;
    logic                       i_rst_n;
    logic                       i_in_valid;
    t_in_item                   i_in_item;
    logic                       o_in_stall;
    logic                       o_out_valid;
    t_out_item                  o_out_item;
    logic                       i_out_stall;
    logic                       i_cfg_we;
    logic [CFG_INDEX_WIDTH-1:0] i_cfg_index;
    logic [CFG_WIDTH-1:0]       i_cfg_data;

    // Stimulus waiting to be sent and LED states waiting to be seen.
    t_in_item  pending_led_inputs[$];
    t_out_item expected_led_states[$];

    // Idle rates of the two sides, in percent.
    int unsigned in_idle_pct   = 28;
    int unsigned out_stall_pct = 28;

    logic in_taken      = 1'b0;
    int   quiet_cycles  = 0;
    int   mismatch_count = 0;

    // Predicted state of the pattern logic.
    t_mode                 led_mode;
    logic [3:0]            led_phase;
    logic [TICK_WIDTH-1:0] ticks_left;
    logic                  timer_on;
    logic                  status_lit;
    logic                  error_lit;
    logic [CFG_WIDTH-1:0]  durations [0:3];

    network_status_led_pattern_driver #(
        .TICK_WIDTH (TICK_WIDTH)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_item   (i_in_item),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item),
        .i_out_stall (i_out_stall),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // Clock.
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Starts the pattern timer. A zero duration counts as one tick. With a
    // 16-bit counter every register value fits, so no saturation is needed.
    function automatic void arm_timer(input logic [CFG_WIDTH-1:0] ticks);
        ticks_left = (ticks == '0) ? TICK_WIDTH'(1) : TICK_WIDTH'(ticks);
        timer_on   = 1'b1;
    endfunction

    // Timer expiry: moves the pattern one phase on. Returns 1 when the
    // status level is reported.
    function automatic bit advance_pattern();
        logic [4:0] next_phase;
        logic [4:0] group_end;
        next_phase = {1'b0, led_phase} + 5'd1;
        case (led_mode)
            MODE_FLICKER, MODE_BLINK: begin
                if (next_phase >= 5'd2) begin
                    next_phase = '0;
                    status_lit = 1'b0;
                end else begin
                    status_lit = 1'b1;
                end
                arm_timer(led_mode == MODE_FLICKER ? durations[CFG_FLICKER]
                                                   : durations[CFG_BLINK]);
            end
            MODE_SINGLE, MODE_DOUBLE, MODE_TRIPLE: begin
                // One on pulse and one gap per flash in the group.
                group_end = (led_mode == MODE_SINGLE) ? 5'd2 :
                            (led_mode == MODE_DOUBLE) ? 5'd4 : 5'd6;
                if (next_phase >= group_end) begin
                    next_phase = '0;
                    status_lit = 1'b0;
                    arm_timer(durations[CFG_FLASH_OFF]);
                end else begin
                    status_lit = next_phase[0];
                    arm_timer(durations[CFG_FLASH_ON]);
                end
            end
            default: begin
                timer_on   = 1'b0;
                ticks_left = '0;
                return 1'b0;
            end
        endcase
        led_phase = next_phase[3:0];
        return 1'b1;
    endfunction

    // State change event on the status LED. Returns 1 when the status level
    // is reported.
    function automatic bit select_pattern(input logic [2:0] status_class);
        t_mode target;
        t_mode prior;
        logic  lit;
        case (status_class)
            CLS_OFF:     target = MODE_OFF;
            CLS_ON:      target = MODE_ON;
            CLS_FLICKER: target = MODE_FLICKER;
            CLS_BLINK:   target = MODE_BLINK;
            CLS_SINGLE:  target = MODE_SINGLE;
            CLS_DOUBLE:  target = MODE_DOUBLE;
            CLS_TRIPLE:  target = MODE_TRIPLE;
            default:     return 1'b0;
        endcase
        prior = led_mode;
        if (target == prior) begin
            return 1'b0;
        end
        led_mode = target;

        // Steady off or on stops the timer but keeps the phase.
        if (target == MODE_OFF || target == MODE_ON) begin
            timer_on   = 1'b0;
            ticks_left = '0;
            status_lit = (target == MODE_ON);
            return 1'b1;
        end

        // Only a start from steady off or on restarts the pattern; a switch
        // between patterns keeps the running phase and timer.
        if (prior == MODE_OFF) begin
            lit       = 1'b1;
            led_phase = PHASE_TOP;
        end else if (prior == MODE_ON) begin
            lit       = 1'b0;
            led_phase = '0;
        end else begin
            return 1'b0;
        end
        case (target)
            MODE_FLICKER: arm_timer(durations[CFG_FLICKER]);
            MODE_BLINK:   arm_timer(durations[CFG_BLINK]);
            default:      arm_timer(lit ? durations[CFG_FLASH_ON] : durations[CFG_FLASH_OFF]);
        endcase
        status_lit = lit;
        return 1'b1;
    endfunction

    // LED state that one accepted transaction leads to.
    function automatic t_out_item predict_led_state(input t_in_item item);
        t_out_item state;
        bit        status_rep;
        bit        error_rep;
        status_rep = 1'b0;
        error_rep  = 1'b0;
        if (item.operation == OP_TICK) begin
            if (timer_on) begin
                if (ticks_left <= 1) begin
                    ticks_left = '0;
                    status_rep = advance_pattern();
                end else begin
                    ticks_left = ticks_left - 1'b1;
                end
            end
        end else begin
            status_rep = select_pattern(item.status_class);
            if (item.error_action == ERR_CLEAR) begin
                error_lit = 1'b0;
                error_rep = 1'b1;
            end else if (item.error_action == ERR_SET) begin
                error_lit = 1'b1;
                error_rep = 1'b1;
            end
        end
        state.status_led    = status_lit;
        state.status_report = status_rep;
        state.error_led     = error_lit;
        state.error_report  = error_rep;
        return state;
    endfunction

    // Input side: a new transaction goes out once the previous one is taken.
    always @(negedge i_clk) begin
        if (i_rst_n && (!i_in_valid || in_taken)) begin
            if (pending_led_inputs.size() != 0 && $urandom_range(0, 99) >= in_idle_pct) begin
                i_in_valid <= 1'b1;
                i_in_item  <= pending_led_inputs.pop_front();
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Output side: random back-pressure.
    always @(negedge i_clk) begin
        i_out_stall <= ($urandom_range(0, 99) < out_stall_pct);
    end

    // Prediction, result checking and watchdog.
    always @(posedge i_clk) begin
        t_out_item want;
        logic      in_acc;
        logic      out_acc;
        in_acc  = i_rst_n && i_in_valid && !o_in_stall;
        out_acc = i_rst_n && o_out_valid && !i_out_stall;
        in_taken <= in_acc;

        if (out_acc) begin
            if (expected_led_states.size() == 0) begin
                mismatch_count <= mismatch_count + 1;
                if (mismatch_count < 10) begin
                    $display("%0t: result with no prediction pending: %b", $realtime,
                             o_out_item);
                end
            end else begin
                want = expected_led_states.pop_front();
                if (o_out_item.status_led    !== want.status_led    ||
                    o_out_item.status_report !== want.status_report ||
                    o_out_item.error_led     !== want.error_led     ||
                    o_out_item.error_report  !== want.error_report) begin
                    mismatch_count <= mismatch_count + 1;
                    if (mismatch_count < 10) begin
                        $display("%0t: LED state mismatch, expected status %b/%b error %b/%b,",
                                 $realtime, want.status_led, want.status_report,
                                 want.error_led, want.error_report);
                        $display("    got status %b/%b error %b/%b",
                                 o_out_item.status_led, o_out_item.status_report,
                                 o_out_item.error_led, o_out_item.error_report);
                    end
                end
            end
        end

        if (in_acc) begin
            expected_led_states.push_back(predict_led_state(i_in_item));
        end

        if (in_acc || out_acc) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("[network_status_led_pattern_driver] ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Queues one transaction.
    function automatic void send(input logic op, input logic [2:0] cls, input logic [1:0] err);
        t_in_item item;
        item.operation    = op;
        item.status_class = cls;
        item.error_action = err;
        pending_led_inputs.push_back(item);
    endfunction

    // Queues random transactions, mostly ticks so that patterns get to run.
    function automatic void send_random(input int count);
        for (int n = 0; n < count; n++) begin
            send(($urandom_range(0, 99) < 25) ? OP_EVENT : OP_TICK,
                 3'($urandom_range(0, 7)), 2'($urandom_range(0, 3)));
        end
    endfunction

    // Waits until the block has nothing in flight.
    task automatic settle();
        while (pending_led_inputs.size() != 0 || i_in_valid || expected_led_states.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Writes one duration register.
    task automatic write_duration(input t_cfg_index idx, input logic [CFG_WIDTH-1:0] value);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
        durations[idx] = value;
    endtask

    // Writes all four duration registers.
    task automatic program_durations(input logic [CFG_WIDTH-1:0] flicker,
                                     input logic [CFG_WIDTH-1:0] blink,
                                     input logic [CFG_WIDTH-1:0] flash_on,
                                     input logic [CFG_WIDTH-1:0] flash_off);
        write_duration(CFG_FLICKER, flicker);
        write_duration(CFG_BLINK, blink);
        write_duration(CFG_FLASH_ON, flash_on);
        write_duration(CFG_FLASH_OFF, flash_off);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Test sequence.
    initial begin
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_item   = '0;
        i_out_stall = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;

        led_mode   = MODE_INIT;
        led_phase  = '0;
        ticks_left = '0;
        timer_on   = 1'b0;
        status_lit = 1'b0;
        error_lit  = 1'b0;
        durations[CFG_FLICKER]   = FLICKER_RESET;
        durations[CFG_BLINK]     = BLINK_RESET;
        durations[CFG_FLASH_ON]  = FLASH_ON_RESET;
        durations[CFG_FLASH_OFF] = FLASH_OFF_RESET;

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Initial mode with default durations: idle tick, no change, pattern
        // selected without a timer, error actions including the unused code,
        // then steady off, repeated once, and steady on.
        send(OP_TICK,  CLS_TRIPLE,    ERR_SET);
        send(OP_EVENT, CLS_NO_CHANGE, ERR_NONE);
        send(OP_EVENT, CLS_FLICKER,   ERR_SET);
        send(OP_EVENT, CLS_BLINK,     2'd3);
        send(OP_EVENT, CLS_BLINK,     ERR_CLEAR);
        send(OP_EVENT, CLS_OFF,       ERR_NONE);
        send(OP_EVENT, CLS_OFF,       ERR_NONE);
        send(OP_EVENT, CLS_ON,        ERR_SET);
        settle();

        // Short durations: pattern entry from on and from off, expiries,
        // switches between patterns and full flash groups.
        program_durations(16'd1, 16'd2, 16'd1, 16'd3);
        send(OP_EVENT, CLS_FLICKER, ERR_NONE);
        send(OP_TICK,  CLS_NO_CHANGE, ERR_NONE);
        send(OP_TICK,  CLS_NO_CHANGE, ERR_NONE);
        send(OP_EVENT, CLS_BLINK, ERR_NONE);
        send(OP_TICK,  CLS_NO_CHANGE, ERR_NONE);
        send(OP_EVENT, CLS_OFF, ERR_NONE);
        send(OP_EVENT, CLS_TRIPLE, ERR_CLEAR);
        repeat (5) send(OP_TICK, CLS_OFF, ERR_NONE);
        send(OP_EVENT, CLS_ON, ERR_SET);
        send(OP_EVENT, CLS_SINGLE, ERR_NONE);
        repeat (3) send(OP_TICK, CLS_ON, ERR_CLEAR);
        send(OP_EVENT, CLS_DOUBLE, ERR_NONE);
        settle();

        // Random phases, one per set of durations.
        program_durations(16'd1, 16'd1, 16'd1, 16'd1);
        send_random(300);
        settle();

        program_durations(16'($urandom_range(1, 8)), 16'($urandom_range(1, 8)),
                          16'($urandom_range(1, 8)), 16'($urandom_range(1, 8)));
        send_random(300);
        settle();

        // Full rate on both sides.
        in_idle_pct   = 0;
        out_stall_pct = 0;
        program_durations(16'($urandom_range(1, 4)), 16'($urandom_range(1, 4)),
                          16'($urandom_range(1, 4)), 16'($urandom_range(1, 4)));
        send_random(300);
        settle();

        in_idle_pct   = 28;
        out_stall_pct = 28;
        program_durations(16'hFFFF, 16'd1, 16'd2, 16'hFFFF);
        send_random(200);
        settle();

        program_durations(16'($urandom_range(1, 6)), 16'($urandom_range(1, 6)),
                          16'($urandom_range(1, 6)), 16'($urandom_range(1, 12)));
        send_random(300);
        settle();

        program_durations(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_random(100);
        settle();

        program_durations(16'($urandom_range(1, 65535)), 16'($urandom_range(1, 65535)),
                          16'($urandom_range(1, 65535)), 16'($urandom_range(1, 65535)));
        send_random(100);
        settle();

        if (mismatch_count == 0) begin
            $display("[network_status_led_pattern_driver] OK");
        end else begin
            $display("[network_status_led_pattern_driver] ERROR");
        end
        $finish;
    end

endmodule
